@@ rtl/ups_patch_stream_decoder_assert.svh @@
// Assertion macros for the UPS patch stream decoder.
// Depends on nothing; included by the top level after its logic.
`ifndef UPS_PATCH_STREAM_DECODER_ASSERT_SVH
`define UPS_PATCH_STREAM_DECODER_ASSERT_SVH

// Antecedent in a cycle implies consequent in the same cycle.
`define UPS_ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Antecedent in a cycle implies consequent in the next cycle.
`define UPS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

@@ rtl/ups_psd_pkg.sv @@
// Shared constants and helpers for the UPS patch stream decoder.
// No dependencies; used by ups_patch_stream_decoder.
package ups_psd_pkg;

  localparam int unsigned AddrBitsDefault = 32;
  localparam int unsigned TrailerLen      = 12;
  localparam int unsigned ResDataBits     = 104;

  // Result kinds
  localparam logic [2:0] KIND_SRC_SIZE = 3'd0;
  localparam logic [2:0] KIND_TGT_SIZE = 3'd1;
  localparam logic [2:0] KIND_XOR      = 3'd2;
  localparam logic [2:0] KIND_SRC_CRC  = 3'd3;
  localparam logic [2:0] KIND_TGT_CRC  = 3'd4;
  localparam logic [2:0] KIND_ERROR    = 3'd5;

  // Error codes
  localparam logic [2:0] ERR_NONE      = 3'd0;
  localparam logic [2:0] ERR_MAGIC     = 3'd1;
  localparam logic [2:0] ERR_TRUNCATED = 3'd2;
  localparam logic [2:0] ERR_TRAILER   = 3'd3;
  localparam logic [2:0] ERR_ADDRESS   = 3'd4;

  // Magic "UPS1", one byte per position
  function automatic logic [7:0] magic_byte(input logic [1:0] idx);
    logic [7:0] b;
    case (idx)
      2'd0:    b = 8'h55;
      2'd1:    b = 8'h50;
      2'd2:    b = 8'h53;
      default: b = 8'h31;
    endcase
    return b;
  endfunction

endpackage

@@ rtl/ups_patch_stream_decoder.sv @@
// UPS patch stream decoder top level.
// Depends on ups_psd_pkg and ups_patch_stream_decoder_assert.svh.

// Takes one patch byte per beat and returns at most one command per byte:
// source size, target size, XOR write, source CRC, target CRC or an error.
// A byte is accepted in every cycle while the result register is free or
// being drained; its result appears on the master side in the cycle after
// acceptance. Each byte passes a single stage of logic (one 64-bit varint
// shift-and-add, address update and bound compares) into the result register.
// Set patch_length over the configuration channel while the block is idle;
// a beat with tuser high restarts the parse at patch byte 0.
module ups_patch_stream_decoder #(
  parameter int unsigned ADDR_BITS = ups_psd_pkg::AddrBitsDefault
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  // Configuration: patch_length
  input  logic                                  cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  logic [31:0]                           cfg_data_i,
  // Patch input
  input  logic                                  s_axis_tvalid,
  output logic                                  s_axis_tready,
  input  logic [7:0]                            s_axis_tdata,  // patch_byte
  input  logic                                  s_axis_tuser,  // first
  // Command output
  output logic                                  m_axis_tvalid,
  input  logic                                  m_axis_tready,
  // address [31:0], value [95:32], error_code [98:96], zeros above
  output logic [ups_psd_pkg::ResDataBits-1:0]   m_axis_tdata,
  output logic [2:0]                            m_axis_tuser   // kind
);

  typedef enum logic [2:0] {
    PH_IDLE, PH_MAGIC, PH_SRC, PH_TGT, PH_SKIP, PH_XOR, PH_CRC, PH_DONE
  } phase_e;

  // Configuration and trailer start
  logic [31:0] patch_length_q, trailer_start_q;

  // Parser state
  phase_e                phase_q, phase_d;
  logic [31:0]           bytes_q, bytes_d;
  logic [63:0]           accum_q, accum_d;
  logic [6:0]            shift_q, shift_d;
  logic [ADDR_BITS-1:0]  taddr_q, taddr_d;
  logic [63:0]           tsize_q, tsize_d;
  logic [31:0]           crc_q, crc_d;
  logic [3:0]            bif_q, bif_d;

  // State as seen by the current byte, after a restart if first is set
  phase_e                e_phase;
  logic [31:0]           e_bytes;
  logic [63:0]           e_accum;
  logic [6:0]            e_shift;
  logic [ADDR_BITS-1:0]  e_taddr;
  logic [63:0]           e_tsize;
  logic [31:0]           e_crc;
  logic [3:0]            e_bif;

  // Varint step
  logic [63:0] feed_accum;
  logic [6:0]  feed_shift;
  logic        feed_done;

  // Result of this byte
  logic        res_valid;
  logic [2:0]  res_kind, res_err;
  logic [31:0] res_addr;
  logic [63:0] res_value;

  logic [7:0]  b;
  logic [1:0]  crc_k;
  logic [3:0]  bif_inc;
  logic        in_fire, out_valid_q;
  logic [2:0]  out_kind_q, out_err_q;
  logic [31:0] out_addr_q;
  logic [63:0] out_value_q;

  assign b             = s_axis_tdata;
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign cfg_ready_o   = 1'b1;

  // Restart view of the state
  always_comb begin
    if (s_axis_tuser) begin
      e_phase = PH_MAGIC;
      e_bytes = '0;
      e_accum = '0;
      e_shift = '0;
      e_taddr = '0;
      e_tsize = '0;
      e_crc   = '0;
      e_bif   = '0;
    end else begin
      e_phase = phase_q;
      e_bytes = bytes_q;
      e_accum = accum_q;
      e_shift = shift_q;
      e_taddr = taddr_q;
      e_tsize = tsize_q;
      e_crc   = crc_q;
      e_bif   = bif_q;
    end
  end

  // Biased varint: the continuation bias lands at bit shift+7, i.e. bit 7 of the term
  always_comb begin
    feed_done = b[7];
    if (!e_shift[6]) begin
      feed_accum = e_accum + (64'({~b[7], b[6:0]}) << e_shift[5:0]);
      feed_shift = e_shift + 7'd7;
    end else begin
      feed_accum = e_accum;
      feed_shift = e_shift;
    end
  end

  assign crc_k   = e_bif[1:0];
  assign bif_inc = e_bif + 4'd1;

  // Parse one byte
  always_comb begin
    phase_d   = e_phase;
    bytes_d   = e_bytes;
    accum_d   = e_accum;
    shift_d   = e_shift;
    taddr_d   = e_taddr;
    tsize_d   = e_tsize;
    crc_d     = e_crc;
    bif_d     = e_bif;
    res_valid = 1'b0;
    res_kind  = ups_psd_pkg::KIND_ERROR;
    res_addr  = '0;
    res_value = '0;
    res_err   = ups_psd_pkg::ERR_NONE;
    if (e_phase != PH_IDLE && e_phase != PH_DONE) begin
      if (e_bytes != 32'hFFFF_FFFF) begin
        bytes_d = e_bytes + 32'd1;
      end
      if (e_bytes >= patch_length_q) begin
        phase_d   = PH_DONE;
        res_valid = 1'b1;
        res_err   = ups_psd_pkg::ERR_TRUNCATED;
      end else begin
        case (e_phase)
          PH_MAGIC: begin
            if (b != ups_psd_pkg::magic_byte(e_bytes[1:0])) begin
              phase_d   = PH_DONE;
              res_valid = 1'b1;
              res_err   = ups_psd_pkg::ERR_MAGIC;
            end else if (e_bytes >= 32'd3) begin
              phase_d = PH_SRC;
            end
          end
          PH_SRC, PH_TGT: begin
            if (feed_done) begin
              accum_d   = '0;
              shift_d   = '0;
              res_valid = 1'b1;
              res_value = feed_accum;
              if (e_phase == PH_SRC) begin
                phase_d  = PH_TGT;
                res_kind = ups_psd_pkg::KIND_SRC_SIZE;
              end else begin
                phase_d  = PH_SKIP;
                tsize_d  = feed_accum;
                res_kind = ups_psd_pkg::KIND_TGT_SIZE;
              end
            end else begin
              accum_d = feed_accum;
              shift_d = feed_shift;
            end
          end
          PH_SKIP: begin
            if (e_shift == '0 && e_bytes >= trailer_start_q) begin
              phase_d = PH_CRC;
              bif_d   = 4'd1;
              crc_d   = 32'(b);
            end else if (feed_done) begin
              taddr_d = e_taddr + feed_accum[ADDR_BITS-1:0];
              accum_d = '0;
              shift_d = '0;
              phase_d = PH_XOR;
            end else begin
              accum_d = feed_accum;
              shift_d = feed_shift;
            end
          end
          PH_XOR: begin
            res_valid = 1'b1;
            if (e_bytes >= trailer_start_q) begin
              phase_d = PH_DONE;
              res_err = ups_psd_pkg::ERR_TRAILER;
            end else if (64'(e_taddr) >= e_tsize) begin
              phase_d = PH_DONE;
              res_err = ups_psd_pkg::ERR_ADDRESS;
            end else begin
              taddr_d   = e_taddr + ADDR_BITS'(1);
              res_kind  = ups_psd_pkg::KIND_XOR;
              res_addr  = 32'(e_taddr);
              res_value = 64'(b);
              if (b == 8'd0) begin
                phase_d = PH_SKIP;
              end
            end
          end
          PH_CRC: begin
            if (crc_k == 2'd0) begin
              crc_d = 32'(b);
            end else begin
              crc_d = e_crc | (32'(b) << {crc_k, 3'b000});
            end
            bif_d = bif_inc;
            if (bif_inc == 4'd4) begin
              res_valid = 1'b1;
              res_kind  = ups_psd_pkg::KIND_SRC_CRC;
              res_value = 64'(crc_d);
            end else if (bif_inc == 4'd8) begin
              phase_d   = PH_DONE;
              res_valid = 1'b1;
              res_kind  = ups_psd_pkg::KIND_TGT_CRC;
              res_value = 64'(crc_d);
            end
          end
          default: begin
            phase_d = e_phase;
          end
        endcase
      end
    end
  end

  // Hold configuration and precompute where the trailer starts
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      patch_length_q  <= '0;
      trailer_start_q <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      patch_length_q <= cfg_data_i;
      if (cfg_data_i >= 32'(ups_psd_pkg::TrailerLen)) begin
        trailer_start_q <= cfg_data_i - 32'(ups_psd_pkg::TrailerLen);
      end else begin
        trailer_start_q <= '0;
      end
    end
  end

  // Advance parser state on each accepted beat
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      bytes_q <= '0;
      accum_q <= '0;
      shift_q <= '0;
      taddr_q <= '0;
      tsize_q <= '0;
      crc_q   <= '0;
      bif_q   <= '0;
    end else if (in_fire) begin
      phase_q <= phase_d;
      bytes_q <= bytes_d;
      accum_q <= accum_d;
      shift_q <= shift_d;
      taddr_q <= taddr_d;
      tsize_q <= tsize_d;
      crc_q   <= crc_d;
      bif_q   <= bif_d;
    end
  end

  // Result register: load on accept, drop once taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_fire) begin
      out_valid_q <= res_valid;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire && res_valid) begin
      out_kind_q  <= res_kind;
      out_addr_q  <= res_addr;
      out_value_q <= res_value;
      out_err_q   <= res_err;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_kind_q;
  assign m_axis_tdata  = ups_psd_pkg::ResDataBits'({out_err_q, out_value_q, out_addr_q});

  `include "ups_patch_stream_decoder_assert.svh"

  `UPS_ASSERT_SAME(a_err_has_code, clk_i, rst_ni,
    m_axis_tvalid && m_axis_tuser == ups_psd_pkg::KIND_ERROR,
    out_err_q != ups_psd_pkg::ERR_NONE)
  `UPS_ASSERT_SAME(a_cmd_no_code, clk_i, rst_ni,
    m_axis_tvalid && m_axis_tuser != ups_psd_pkg::KIND_ERROR,
    out_err_q == ups_psd_pkg::ERR_NONE)
  `UPS_ASSERT_NEXT(a_first_starts, clk_i, rst_ni,
    s_axis_tvalid && s_axis_tready && s_axis_tuser,
    phase_q != PH_IDLE)

endmodule
